// ===== sv/poly_voice_allocator_unit_defines.svh =====
// Assertion macros shared by the voice allocator RTL.
`ifndef POLY_VOICE_ALLOCATOR_UNIT_DEFINES_SVH
`define POLY_VOICE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define PVA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PVA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PVA_ASSERT(lbl, clk, rst, prop, msg)
`define PVA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/pva_pkg.sv =====
`default_nettype none

package pva_pkg;

   localparam int NUM_VOICES_DEF    = 16;
   localparam int VOICE_COUNT_RESET = 16;
   localparam int QUEUE_DEPTH       = 2;

   // request type codes
   localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
   localparam logic [1:0] REQ_NOTE_OFF = 2'd1;

   // result action codes
   localparam logic [1:0] ACT_ON  = 2'd0;
   localparam logic [1:0] ACT_OFF = 2'd1;
   localparam logic [1:0] ACT_ALL = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [6:0]  key;
      logic [6:0]  velocity;
      logic [15:0] active_mask;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] deliver_mask;
      logic [3:0]  chosen_voice;
      logic        chosen_valid;
      logic [6:0]  out_key;
      logic [6:0]  out_velocity;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      OP_ON,
      OP_OFF,
      OP_ALL
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [6:0]  key;
      logic [6:0]  velocity;
      logic [15:0] active_mask;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } eng_state_type;

endpackage

`default_nettype wire

// ===== sv/poly_voice_allocator_unit.sv =====
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_payload_type: type, key, velocity, mask
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_payload_type: action, mask, voice, key
//  csr     | in        | csr_valid/csr_ready  | csr_wdata: voice count, 5 bits
//
//  Note-on and note-off pass through dispatch, a scan of one voice per cycle and completion
//  in the back end; broadcasts skip the scan. The per-voice scan with
//  its 64-bit tick compare sets the rate. A two-entry queue takes requests while the back
//  end works or a result waits. Reset is synchronous and clears every voice at once;
//  a voice-count change also clears all voices but keeps the tick counter.
`default_nettype none

module poly_voice_allocator_unit #(
   parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  pva_pkg::req_payload_type  req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output pva_pkg::rsp_payload_type  rsp_data,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire  [4:0]                csr_wdata
);
   import pva_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   pva_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   pva_engine #(
      .NUM_VOICES (NUM_VOICES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire

// ===== sv/pva_front.sv =====
`default_nettype none
`include "poly_voice_allocator_unit_defines.svh"

module pva_front (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  pva_pkg::req_payload_type  req_data,
   output logic                      cmd_valid,
   output pva_pkg::cmd_type          cmd,
   input  wire                       cmd_pop
);
   import pva_pkg::*;

   localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   cmd_type          queue_ff [QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             push, pop;
   cmd_type          cmd_new;

   assign req_stall = (count_ff == QCW'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = queue_ff[rd_ptr_ff];

   // note-on with zero velocity is a note-off
   always_comb begin
      cmd_new.key         = req_data.key;
      cmd_new.velocity    = req_data.velocity;
      cmd_new.active_mask = req_data.active_mask;
      if (req_data.req_type == REQ_NOTE_ON && req_data.velocity != '0) begin
         cmd_new.op = OP_ON;
      end else if (req_data.req_type inside {REQ_NOTE_ON, REQ_NOTE_OFF}) begin
         cmd_new.op = OP_OFF;
      end else begin
         cmd_new.op = OP_ALL;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   `PVA_ASSERT(a_queue_bound, clock, reset, count_ff <= QCW'(QUEUE_DEPTH), "queue overfilled")

endmodule

`default_nettype wire

// ===== sv/pva_engine.sv =====
`default_nettype none
`include "poly_voice_allocator_unit_defines.svh"

module pva_engine #(
   parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       cmd_valid,
   input  pva_pkg::cmd_type          cmd,
   output logic                      cmd_pop,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output pva_pkg::rsp_payload_type  rsp_data,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire  [4:0]                csr_wdata
);
   import pva_pkg::*;

   localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CW = $clog2(NUM_VOICES + 1);
   localparam int CountReset = (VOICE_COUNT_RESET > NUM_VOICES) ? NUM_VOICES
                                                                : VOICE_COUNT_RESET;

   eng_state_type      state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [CW-1:0]      count_ff;
   logic               found_match_ff, found_match_in;
   logic [IW-1:0]      match_idx_ff, match_idx_in;
   logic               found_free_ff, found_free_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [63:0]        best_tick_ff, best_tick_in;
   logic [15:0]        mask_ff, mask_in;
   logic [63:0]        tick_counter_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic [NUM_VOICES-1:0] held_valid_ff;
   logic [NUM_VOICES-1:0] tick_valid_ff;
   logic [6:0]            held_note_ff  [NUM_VOICES];
   logic [63:0]           start_tick_ff [NUM_VOICES];

   logic [IW-1:0]      scan_idx;
   logic [IW-1:0]      chosen_idx;
   logic [31:0]        act_ext;
   logic               v_held, v_act, v_hit;
   logic [63:0]        v_tick;
   logic               off_clear, on_commit;
   logic               out_free;
   logic [CW-1:0]      csr_count;
   logic               cfg_clear;
   logic [15:0]        all_mask;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign scan_idx = scan_ff[IW-1:0];
   assign act_ext  = 32'(cmd_ff.active_mask);
   assign v_held   = held_valid_ff[scan_idx];
   assign v_act    = act_ext[scan_idx];
   assign v_hit    = v_held && (held_note_ff[scan_idx] == cmd_ff.key);
   assign v_tick   = tick_valid_ff[scan_idx] ? start_tick_ff[scan_idx] : '0;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign chosen_idx = found_match_ff ? match_idx_ff :
                       found_free_ff  ? free_idx_ff  : best_idx_ff;

   always_comb begin
      if (csr_wdata == '0) begin
         csr_count = CW'(1);
      end else if (32'(csr_wdata) > 32'(NUM_VOICES)) begin
         csr_count = CW'(NUM_VOICES);
      end else begin
         csr_count = CW'(csr_wdata);
      end
   end
   assign cfg_clear = csr_valid && csr_ready && (csr_count != count_ff);

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         all_mask[i] = (32'(i) < 32'(count_ff));
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      scan_in        = scan_ff;
      found_match_in = found_match_ff;
      match_idx_in   = match_idx_ff;
      found_free_in  = found_free_ff;
      free_idx_in    = free_idx_ff;
      best_idx_in    = best_idx_ff;
      best_tick_in   = best_tick_ff;
      mask_in        = mask_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cmd_pop        = 1'b0;
      off_clear      = 1'b0;
      on_commit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop        = 1'b1;
               cmd_in         = cmd;
               scan_in        = '0;
               found_match_in = 1'b0;
               found_free_in  = 1'b0;
               mask_in        = '0;
               state_in       = (cmd.op == OP_ALL) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmd_ff.op == OP_ON) begin
               if (!found_match_ff && v_hit && v_act) begin
                  found_match_in = 1'b1;
                  match_idx_in   = scan_idx;
               end
               if (!found_free_ff && !v_held && !v_act) begin
                  found_free_in = 1'b1;
                  free_idx_in   = scan_idx;
               end
               // strict compare keeps the lowest index on a tie
               if (scan_ff == '0 || v_tick < best_tick_ff) begin
                  best_idx_in  = scan_idx;
                  best_tick_in = v_tick;
               end
            end else if (v_hit) begin
               mask_in   = mask_ff | (16'(1) << scan_idx);
               off_clear = 1'b1;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == count_ff - 1'b1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.out_key      = cmd_ff.key;
               rsp_in.out_velocity = cmd_ff.velocity;
               rsp_in.chosen_voice = '0;
               rsp_in.chosen_valid = 1'b0;
               case (cmd_ff.op)
                  OP_ON: begin
                     on_commit           = 1'b1;
                     rsp_in.action       = ACT_ON;
                     rsp_in.deliver_mask = 16'(1) << chosen_idx;
                     rsp_in.chosen_voice = 4'(chosen_idx);
                     rsp_in.chosen_valid = 1'b1;
                  end
                  OP_OFF: begin
                     rsp_in.action       = ACT_OFF;
                     rsp_in.deliver_mask = mask_ff;
                  end
                  default: begin
                     rsp_in.action       = ACT_ALL;
                     rsp_in.deliver_mask = all_mask;
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         tick_counter_ff <= '0;
         count_ff        <= CW'(CountReset);
         held_valid_ff   <= '0;
         tick_valid_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (on_commit) begin
            tick_counter_ff <= tick_counter_ff + 64'd1;
         end
         if (cfg_clear) begin
            count_ff      <= csr_count;
            held_valid_ff <= '0;
            tick_valid_ff <= '0;
         end else begin
            if (off_clear) begin
               held_valid_ff[scan_idx] <= 1'b0;
            end
            if (on_commit) begin
               held_valid_ff[chosen_idx] <= 1'b1;
               tick_valid_ff[chosen_idx] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      scan_ff        <= scan_in;
      found_match_ff <= found_match_in;
      match_idx_ff   <= match_idx_in;
      found_free_ff  <= found_free_in;
      free_idx_ff    <= free_idx_in;
      best_idx_ff    <= best_idx_in;
      best_tick_ff   <= best_tick_in;
      mask_ff        <= mask_in;
      rsp_ff         <= rsp_in;
      if (on_commit) begin
         held_note_ff[chosen_idx]  <= cmd_ff.key;
         start_tick_ff[chosen_idx] <= tick_counter_ff;
      end
   end

   `PVA_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "result raised outside completion")
   `PVA_ASSERT(a_scan_in_range, clock, reset, (state_ff == ST_SCAN) |-> (scan_ff < count_ff), "scan index past voice count")
   `PVA_ASSERT(a_tick_only_on, clock, reset, (tick_counter_ff != $past(tick_counter_ff)) |-> $past(on_commit), "tick moved without note-on")
   `PVA_ASSERT(a_chosen_flag, clock, reset, rsp_valid_ff |-> (rsp_ff.chosen_valid == (rsp_ff.action == ACT_ON)), "chosen flag disagrees with action")

endmodule

`default_nettype wire
